FILE: src/bba_pkg.sv
// bba_pkg: shared constants for the first-fit bitmap block allocator
// sizes of the bitmap memory, field widths and result status codes
// no dependencies
package bba_pkg;

   // field widths fixed by the interface
   localparam int INDEX_W = 12;
   localparam int COUNT_W = 13;
   localparam int STATUS_W = 2;

   // bitmap organization: one memory word holds the bits of 64 blocks
   localparam int BIT_W = 6;
   localparam int WORD_W = 1 << BIT_W;
   localparam int WORD_ADDR_W = INDEX_W - BIT_W;
   localparam int WORD_COUNT = 1 << WORD_ADDR_W;
   localparam int MAX_BLOCKS = WORD_COUNT * WORD_W;
   localparam int HI_W = COUNT_W - BIT_W;

   // reset value of the block count register
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_BLOCKS);

   // request actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

FILE: src/bitmap_block_allocator_unit.sv
// allocate scans words from word 0 to the one with the first free block below the count
//   (64 bits per word), or through the last word when full; an in-range free reads its word
// throughput: one request at a time, the next is accepted the cycle after the result
//   is loaded; the allocate scan reads one 64-bit bitmap word per cycle from one port
// reset (synchronous, active high): every block free, block count 4096, no result pending
// the bitmap memory itself is not cleared: a valid flag per word makes unwritten words read zero
module bitmap_block_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [bba_pkg::INDEX_W-1:0]   req_block_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bba_pkg::INDEX_W-1:0]   rsp_given_index,
   output logic [bba_pkg::STATUS_W-1:0]  rsp_status,
   input  logic                          csr_write_enable,
   input  logic [bba_pkg::COUNT_W-1:0]   csr_write_data
);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_FREE_RD = 3'd2;
   localparam logic [2:0] S_FREE_CHK = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   typedef logic [bba_pkg::WORD_W-1:0] word_type;
   typedef logic [bba_pkg::WORD_ADDR_W-1:0] waddr_type;

   // bitmap memory, one bit per block, 1 = used
   word_type mem [bba_pkg::WORD_COUNT];
   // word written since reset; an unwritten word reads as all free
   logic [bba_pkg::WORD_COUNT-1:0] row_valid_ff;

   // control state
   logic [2:0] state_ff, state_in;
   logic [bba_pkg::COUNT_W-1:0] total_blocks_ff;
   logic [bba_pkg::WORD_ADDR_W:0] issue_ff, issue_in;
   logic rd_live_ff;
   logic rsp_valid_ff, rsp_valid_in;

   // request payload and working values
   logic [bba_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic [bba_pkg::COUNT_W-1:0] n_ff, n_in;
   logic [bba_pkg::INDEX_W-1:0] res_index_ff, res_index_in;
   logic [bba_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [bba_pkg::INDEX_W-1:0] rsp_given_index_ff;
   logic [bba_pkg::STATUS_W-1:0] rsp_status_ff;

   // memory read port
   logic rd_en;
   waddr_type rd_addr;
   word_type rd_data_ff;
   logic rd_row_valid_ff;
   waddr_type rd_word_ff;

   // memory write port
   logic wr_en;
   word_type wr_data;

   // datapath
   logic [bba_pkg::COUNT_W-1:0] limit;
   logic accept;
   word_type eff_word;
   word_type word_mask;
   word_type avail;
   logic found;
   logic [bba_pkg::BIT_W-1:0] found_pos;
   logic [bba_pkg::HI_W-1:0] word_hi;
   logic [bba_pkg::HI_W-1:0] word_ext;
   logic [bba_pkg::BIT_W-1:0] free_pos;
   logic last_word;

   // effective block count saturates at the bitmap size
   assign limit = (total_blocks_ff > bba_pkg::COUNT_W'(bba_pkg::MAX_BLOCKS))
                ? bba_pkg::COUNT_W'(bba_pkg::MAX_BLOCKS) : total_blocks_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_given_index = rsp_given_index_ff;
   assign rsp_status = rsp_status_ff;

   // data of the last read word
   assign eff_word = rd_row_valid_ff ? rd_data_ff : '0;

   // bits of the read word that lie below the block count
   assign word_hi = n_ff[bba_pkg::COUNT_W-1:bba_pkg::BIT_W];
   assign word_ext = bba_pkg::HI_W'(rd_word_ff);
   always_comb begin
      if (word_ext < word_hi) begin
         word_mask = '1;
      end else if (word_ext == word_hi) begin
         word_mask = (word_type'(1) << n_ff[bba_pkg::BIT_W-1:0]) - word_type'(1);
      end else begin
         word_mask = '0;
      end
   end

   assign avail = ~eff_word & word_mask;

   // lowest free bit of the word
   always_comb begin
      found = 1'b0;
      found_pos = '0;
      for (int b = bba_pkg::WORD_W - 1; b >= 0; b--) begin
         if (avail[b]) begin
            found = 1'b1;
            found_pos = bba_pkg::BIT_W'(b);
         end
      end
   end

   assign free_pos = idx_ff[bba_pkg::BIT_W-1:0];
   assign last_word = (rd_word_ff == waddr_type'(bba_pkg::WORD_COUNT - 1));

   // sequencer
   always_comb begin
      state_in = state_ff;
      issue_in = issue_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      res_index_in = res_index_ff;
      res_status_in = res_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_en = 1'b0;
      rd_addr = issue_ff[bba_pkg::WORD_ADDR_W-1:0];
      wr_en = 1'b0;
      wr_data = eff_word;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = req_block_index;
               n_in = limit;
               issue_in = '0;
               res_index_in = '0;
               if (req_action == bba_pkg::ACT_ALLOC) begin
                  state_in = S_SCAN;
               end else if (bba_pkg::COUNT_W'(req_block_index) >= limit) begin
                  res_status_in = bba_pkg::ST_RANGE;
                  state_in = S_DONE;
               end else begin
                  state_in = S_FREE_RD;
               end
            end
         end
         S_SCAN: begin
            // one read issued per cycle, the previous word checked alongside
            if (issue_ff < (bba_pkg::WORD_ADDR_W+1)'(bba_pkg::WORD_COUNT)) begin
               rd_en = 1'b1;
               issue_in = issue_ff + 1'b1;
            end
            if (rd_live_ff) begin
               if (found) begin
                  wr_en = 1'b1;
                  wr_data = eff_word | (word_type'(1) << found_pos);
                  res_index_in = {rd_word_ff, found_pos};
                  res_status_in = bba_pkg::ST_OK;
                  state_in = S_DONE;
               end else if (last_word) begin
                  res_status_in = bba_pkg::ST_FULL;
                  state_in = S_DONE;
               end
            end
         end
         S_FREE_RD: begin
            rd_en = 1'b1;
            rd_addr = idx_ff[bba_pkg::INDEX_W-1:bba_pkg::BIT_W];
            state_in = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (eff_word[free_pos]) begin
               wr_en = 1'b1;
               wr_data = eff_word & ~(word_type'(1) << free_pos);
               res_status_in = bba_pkg::ST_OK;
            end else begin
               res_status_in = bba_pkg::ST_NOT_USED;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // wait for the output register to empty
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // bitmap memory: one read and one write port, registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[rd_word_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_row_valid_ff <= row_valid_ff[rd_addr];
         rd_word_ff <= rd_addr;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_valid_ff <= '0;
         total_blocks_ff <= bba_pkg::COUNT_RESET;
         issue_ff <= '0;
         rd_live_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         rd_live_ff <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            row_valid_ff[rd_word_ff] <= 1'b1;
         end
         if (csr_write_enable) begin
            total_blocks_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      n_ff <= n_in;
      res_index_ff <= res_index_in;
      res_status_ff <= res_status_in;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_given_index_ff <= res_index_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

endmodule

FILE: verif/bitmap_block_allocator_unit_tb.sv
// bitmap_block_allocator_unit_tb: self-checking bench for the first-fit block allocator
// predicts every result from its own copy of the bitmap and the block count register
// depends on bba_pkg and bitmap_block_allocator_unit
module bitmap_block_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // tracks the used/free map and holds the results still owed by the block
   class alloc_scoreboard;
      typedef struct packed {
         logic [bba_pkg::INDEX_W-1:0]  given;
         logic [bba_pkg::STATUS_W-1:0] status;
      } outcome_type;

      bit used [bba_pkg::MAX_BLOCKS];
      logic [bba_pkg::COUNT_W-1:0] count_reg;
      outcome_type owed [$];
      int errors;

      function void reset_state();
         foreach (used[i]) used[i] = 1'b0;
         count_reg = bba_pkg::COUNT_RESET;
         owed.delete();
         errors = 0;
      endfunction

      // block count as the allocator sees it, saturated at the bitmap size
      function int managed();
         int n;
         n = count_reg;
         if (n > bba_pkg::MAX_BLOCKS) n = bba_pkg::MAX_BLOCKS;
         return n;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // first used block at or after start, wrapping below the count; -1 if none
      function int find_used(int start);
         int n;
         int hit;
         n = managed();
         hit = -1;
         for (int k = 0; k < n && hit < 0; k++)
            if (used[(start + k) % n]) hit = (start + k) % n;
         return hit;
      endfunction

      // an accepted request: update the map and queue the result it yields
      function void note_request(logic act, logic [bba_pkg::INDEX_W-1:0] idx);
         outcome_type o;
         int n;
         bit found;
         n = managed();
         o.given = '0;
         o.status = bba_pkg::ST_OK;
         found = 1'b0;
         if (act == bba_pkg::ACT_ALLOC) begin
            for (int i = 0; i < n && !found; i++)
               if (!used[i]) begin
                  used[i] = 1'b1;
                  o.given = bba_pkg::INDEX_W'(i);
                  found = 1'b1;
               end
            if (!found) o.status = bba_pkg::ST_FULL;
         end else if (idx >= n) begin
            o.status = bba_pkg::ST_RANGE;
         end else if (!used[idx]) begin
            o.status = bba_pkg::ST_NOT_USED;
         end else begin
            used[idx] = 1'b0;
         end
         owed.push_back(o);
      endfunction

      function void check_result(logic [bba_pkg::INDEX_W-1:0] given,
                                 logic [bba_pkg::STATUS_W-1:0] status);
         outcome_type o;
         if (owed.size() == 0) begin
            $display("%0t: result with none owed, expected none, %s %0d status %0d",
                     $time, "actual given_index", given, status);
            errors++;
            return;
         end
         o = owed.pop_front();
         if (given !== o.given) begin
            $display("%0t: given_index expected %0d actual %0d", $time, o.given, given);
            errors++;
         end
         if (status !== o.status) begin
            $display("%0t: status expected %0d actual %0d", $time, o.status, status);
            errors++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_action = bba_pkg::ACT_ALLOC;
   logic [bba_pkg::INDEX_W-1:0]   req_block_index = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [bba_pkg::INDEX_W-1:0]   rsp_given_index;
   logic [bba_pkg::STATUS_W-1:0]  rsp_status;
   logic                          csr_write_enable = 1'b0;
   logic [bba_pkg::COUNT_W-1:0]   csr_write_data = '0;

   // when set, neither side idles
   bit steady = 1'b0;

   alloc_scoreboard sb;

   bitmap_block_allocator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_given_index  (rsp_given_index),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // receiver: holds ready low with a chance of about 37 in a hundred unless steady
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 37);
   end

   // result monitor: values read here are the ones from before this edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_given_index, rsp_status);
   end

   // one request: optional gap, then hold valid until accepted and log it
   task automatic send_request(input logic act, input logic [bba_pkg::INDEX_W-1:0] idx);
      if (!steady && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_block_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(act, idx);
   endtask

   // sender stops and waits for every owed result
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // block count write, only ever issued with the allocator idle
   task automatic write_count(input logic [bba_pkg::COUNT_W-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.count_reg = value;
   endtask

   task automatic alloc_request();
      // block_index is ignored for allocate, so it carries noise
      send_request(bba_pkg::ACT_ALLOC,
                   bba_pkg::INDEX_W'($urandom_range(0, bba_pkg::MAX_BLOCKS - 1)));
   endtask

   // random phase: mostly allocate and free of live blocks, some noise frees
   task automatic random_phase(input logic [bba_pkg::COUNT_W-1:0] count, input int items);
      int r;
      int n;
      int pick;
      write_count(count);
      for (int k = 0; k < items; k++) begin
         r = $urandom_range(0, 99);
         n = sb.managed();
         pick = -1;
         if (r < 50) begin
            alloc_request();
         end else if (r < 85) begin
            if (n > 0) pick = sb.find_used($urandom_range(0, n - 1));
            if (pick >= 0) send_request(bba_pkg::ACT_FREE, bba_pkg::INDEX_W'(pick));
            else alloc_request();
         end else if (r < 95 || n >= bba_pkg::MAX_BLOCKS) begin
            // arbitrary index: mostly a double free or out of range
            send_request(bba_pkg::ACT_FREE,
                         bba_pkg::INDEX_W'($urandom_range(0, bba_pkg::MAX_BLOCKS - 1)));
         end else begin
            send_request(bba_pkg::ACT_FREE,
                         bba_pkg::INDEX_W'($urandom_range(n, bba_pkg::MAX_BLOCKS - 1)));
         end
         // now and then the sender holds off until the block is drained
         if ($urandom_range(0, 99) < 3) settle();
      end
   endtask

   initial begin
      sb = new();
      sb.reset_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset count 4096, first fit, double free, free of a clear bit
      send_request(bba_pkg::ACT_ALLOC, '0);
      send_request(bba_pkg::ACT_ALLOC, '1);
      send_request(bba_pkg::ACT_ALLOC, '0);
      send_request(bba_pkg::ACT_FREE, 12'd1);
      send_request(bba_pkg::ACT_FREE, 12'd1);
      send_request(bba_pkg::ACT_ALLOC, '0);
      send_request(bba_pkg::ACT_FREE, 12'd4095);
      send_request(bba_pkg::ACT_FREE, 12'd0);
      send_request(bba_pkg::ACT_ALLOC, '1);

      // count above the bitmap size saturates
      write_count(13'h1FFF);
      send_request(bba_pkg::ACT_ALLOC, '0);
      send_request(bba_pkg::ACT_FREE, 12'd4095);

      // zero count: allocate is full, every free out of range
      write_count(13'd0);
      send_request(bba_pkg::ACT_ALLOC, '0);
      send_request(bba_pkg::ACT_FREE, 12'd0);
      send_request(bba_pkg::ACT_FREE, 12'd4095);

      // lowered count: blocks 2 and 3 keep their bits out of reach
      write_count(13'd2);
      send_request(bba_pkg::ACT_ALLOC, '0);
      send_request(bba_pkg::ACT_FREE, 12'd2);
      send_request(bba_pkg::ACT_FREE, 12'd1);
      send_request(bba_pkg::ACT_ALLOC, '0);
      send_request(bba_pkg::ACT_FREE, 12'd0);

      // count raised again: the kept blocks can be freed
      write_count(bba_pkg::COUNT_RESET);
      send_request(bba_pkg::ACT_FREE, 12'd3);
      send_request(bba_pkg::ACT_FREE, 12'd2);

      // random phases over small, word-boundary and extreme counts
      random_phase(13'd1, 60);
      random_phase(13'd5, 60);
      steady = 1'b1;
      random_phase(13'd64, 60);
      steady = 1'b0;
      random_phase(13'd65, 60);
      random_phase(13'd130, 60);
      random_phase(bba_pkg::COUNT_RESET, 60);
      random_phase(13'h1FFF, 60);
      random_phase(bba_pkg::COUNT_W'($urandom_range(1, 300)), 60);
      random_phase(bba_pkg::COUNT_RESET, 60);

      settle();
      repeat (8) @(posedge clock);
      sb.errors += sb.pending();
      if (sb.errors == 0)
         $display("bitmap_block_allocator_unit: match");
      else
         $display("bitmap_block_allocator_unit: mismatch");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5000000;
      $display("bitmap_block_allocator_unit: mismatch");
      $finish;
   end

endmodule
